@@ hw/rtl/pffv_pkg.sv @@
// Shared types and constants for the pixel flame flicker validator.
package pffv_pkg;

  localparam int IDX_W       = 19;
  localparam int CH_W        = 8;
  localparam int AVG_W       = 16;
  localparam int AVG3_W      = 3 * AVG_W;
  localparam int SPR_W       = 17;
  localparam int WT_W        = 9;
  localparam int THR_W       = 17;
  localparam int SUM_W       = 34;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WT_W-1:0]  ONE_FIX      = 9'd256;
  localparam logic [SPR_W-1:0] FLOOR_TARGET = 17'd2560;
  localparam logic [CH_W-1:0]  OVL_BLUE     = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COLOR_WEIGHT,
    REG_SPREAD_WEIGHT,
    REG_SPREAD_THRESHOLD,
    REG_OVERLAY_ENABLE
  } cfg_reg_t;

  // How the back end treats a pixel.
  typedef enum logic [1:0] {
    CLS_PRIME,
    CLS_SKIP,
    CLS_FLAME,
    CLS_PLAIN
  } cls_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    cls_t             cls;
  } item_t;

  typedef struct packed {
    logic [WT_W-1:0]  color_weight;
    logic [WT_W-1:0]  spread_weight;
    logic [THR_W-1:0] spread_threshold;
    logic             overlay_enable;
  } cfg_t;

endpackage

@@ hw/rtl/pffv_if.sv @@
// Channel interfaces: pixel input, result output and configuration writes.
interface pffv_in_if import pffv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [CH_W-1:0]  blue;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  red;
  logic             flame_color;
  logic             frame_end;

  modport source (output valid, pixel_index, blue, green, red, flame_color, frame_end,
                  input ready);
  modport sink (input valid, pixel_index, blue, green, red, flame_color, frame_end,
                output ready);
endinterface

interface pffv_out_if import pffv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            dynamic_flag;
  logic            overlay_write;
  logic [CH_W-1:0] overlay_blue;
  logic [CH_W-1:0] overlay_green;
  logic [CH_W-1:0] overlay_red;

  modport source (output valid, dynamic_flag, overlay_write, overlay_blue, overlay_green,
                  overlay_red, input ready);
  modport sink (input valid, dynamic_flag, overlay_write, overlay_blue, overlay_green,
                overlay_red, output ready);
endinterface

interface pffv_cfg_if import pffv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ hw/rtl/pffv_front.sv @@
// Front end: accepts pixels, tracks the priming frame and classifies each pixel.
module pffv_front import pffv_pkg::*; #(
  parameter int NUM_PIXELS = 524288
) (
  input  logic        clk,
  input  logic        rst,
  pffv_in_if.sink     in_ch,
  input  logic        queue_full,
  output logic        push_valid,
  output item_t       push_item
);

  logic primed;
  logic accept;
  logic in_range;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.pixel_index) < 32'(NUM_PIXELS);

  // The first frame after reset only loads state; frame_end closes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (accept && in_ch.frame_end) begin
      primed <= 1'b1;
    end
  end

  // Classify the pixel for the back end.
  always_comb begin
    push_valid      = accept;
    push_item.idx   = in_ch.pixel_index;
    push_item.blue  = in_ch.blue;
    push_item.green = in_ch.green;
    push_item.red   = in_ch.red;
    if (!in_range) begin
      push_item.cls = CLS_SKIP;
    end else if (!primed) begin
      push_item.cls = CLS_PRIME;
    end else if (in_ch.flame_color) begin
      push_item.cls = CLS_FLAME;
    end else begin
      push_item.cls = CLS_PLAIN;
    end
  end

endmodule

@@ hw/rtl/pffv_queue.sv @@
// Short queue of classified pixels between the front and back ends.
module pffv_queue import pffv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_item  = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push_valid && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push_valid) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/pffv_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module pffv_sqrt import pffv_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] radicand,
  output logic [SPR_W-1:0] root
);

  localparam int REM_W = SUM_W + 2;

  logic [REM_W-1:0] rem [SPR_W];
  logic [SPR_W-1:0] rt  [SPR_W];

  for (genvar k = 0; k < SPR_W; k++) begin : g_stage
    localparam int BIT = SPR_W - 1 - k;
    logic [REM_W-1:0] rem_in;
    logic [SPR_W-1:0] rt_in;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(radicand);
      assign rt_in  = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
    end

    // Try setting this root bit against the running remainder.
    assign trial = (REM_W'(rt_in) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[k] <= rem_in - trial;
          rt[k]  <= rt_in | (SPR_W'(1) << BIT);
        end else begin
          rem[k] <= rem_in;
          rt[k]  <= rt_in;
        end
      end
    end
  end

  assign root = rt[SPR_W-1];

endmodule

@@ hw/rtl/pffv_back.sv @@
// Back end: per-pixel state memories, average updates and the result register.
module pffv_back import pffv_pkg::*; #(
  parameter int NUM_PIXELS = 524288
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  input  item_t       pop_item,
  output logic        pop,
  pffv_out_if.source  out_ch
);

  localparam int AW    = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int NS    = SPR_W;
  localparam int PROD_W = AVG_W + WT_W + 1;
  localparam int SP_W   = SPR_W + WT_W + 1;

  logic [AVG3_W-1:0] avg_mem [NUM_PIXELS];
  logic [SPR_W-1:0]  spr_mem [NUM_PIXELS];

  logic adv;
  logic hazard;
  logic [WT_W-1:0] wc, ws, wc_inv, ws_inv;

  // Stage A: memory read data.
  logic              va;
  item_t             ia;
  logic [AVG3_W-1:0] avg_rd;
  logic [SPR_W-1:0]  spr_rd;
  // Stage B: new color average.
  logic              vb;
  item_t             ib;
  logic [AVG3_W-1:0] nab;
  logic [SPR_W-1:0]  sprb;
  // Stage C: squared distances.
  logic              vc;
  item_t             ic;
  logic [AVG3_W-1:0] nac;
  logic [SPR_W-1:0]  sprc;
  logic [2*AVG_W-1:0] sq [3];
  // Root stages side band.
  logic              sv   [NS];
  item_t             si   [NS];
  logic [AVG3_W-1:0] sna  [NS];
  logic [SPR_W-1:0]  sspr [NS];
  logic [SPR_W-1:0]  root;
  // Stage F: new spread average.
  logic              vf;
  item_t             itf;
  logic [AVG3_W-1:0] naf;
  logic [SPR_W-1:0]  snew;

  logic [AVG3_W-1:0] na_comb;
  logic [SUM_W-1:0]  sum_comb;
  logic [SPR_W-1:0]  target;
  logic [SP_W-1:0]   sp_sum;
  logic              dyn;
  logic              scored;

  // Weights above one are used as one.
  assign wc     = (cfg.color_weight > ONE_FIX) ? ONE_FIX : cfg.color_weight;
  assign ws     = (cfg.spread_weight > ONE_FIX) ? ONE_FIX : cfg.spread_weight;
  assign wc_inv = ONE_FIX - wc;
  assign ws_inv = ONE_FIX - ws;

  // The whole pipeline moves when the result register can take a value.
  assign adv = !out_ch.valid || out_ch.ready;

  // Hold a pixel back while an earlier transaction on the same index is in flight.
  always_comb begin
    hazard = (va && ia.idx == pop_item.idx) || (vb && ib.idx == pop_item.idx) ||
             (vc && ic.idx == pop_item.idx) || (vf && itf.idx == pop_item.idx);
    for (int k = 0; k < NS; k++) begin
      if (sv[k] && si[k].idx == pop_item.idx) begin
        hazard = 1'b1;
      end
    end
  end

  assign pop = pop_valid && !hazard && adv;

  // State memories: read at issue, written as the result leaves stage F.
  always_ff @(posedge clk) begin
    if (adv) begin
      avg_rd <= avg_mem[AW'(pop_item.idx)];
      spr_rd <= spr_mem[AW'(pop_item.idx)];
    end
    if (adv && vf && (itf.cls == CLS_PRIME || itf.cls == CLS_FLAME)) begin
      avg_mem[AW'(itf.idx)] <= (itf.cls == CLS_PRIME) ?
          {itf.blue, 8'd0, itf.green, 8'd0, itf.red, 8'd0} : naf;
    end
    if (adv && vf && itf.cls != CLS_SKIP) begin
      spr_mem[AW'(itf.idx)] <= (itf.cls == CLS_PRIME) ? '0 : snew;
    end
  end

  // Color average update per channel.
  always_comb begin
    logic [PROD_W-1:0] acc;
    logic [AVG_W-1:0]  a;
    logic [AVG_W-1:0]  p;
    for (int k = 0; k < 3; k++) begin
      a = avg_rd[k*AVG_W +: AVG_W];
      case (k)
        0:       p = {ia.red, 8'd0};
        1:       p = {ia.green, 8'd0};
        default: p = {ia.blue, 8'd0};
      endcase
      acc = PROD_W'(a) * PROD_W'(wc_inv) + PROD_W'(p) * PROD_W'(wc);
      na_comb[k*AVG_W +: AVG_W] = acc[8 +: AVG_W];
    end
  end

  assign sum_comb = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

  // Stages A through C.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      va <= pop;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    logic [AVG_W-1:0] p;
    logic [AVG_W-1:0] n;
    logic [AVG_W-1:0] d;
    if (adv) begin
      ia   <= pop_item;
      ib   <= ia;
      nab  <= na_comb;
      sprb <= spr_rd;
      ic   <= ib;
      nac  <= nab;
      sprc <= sprb;
      for (int k = 0; k < 3; k++) begin
        case (k)
          0:       p = {ib.red, 8'd0};
          1:       p = {ib.green, 8'd0};
          default: p = {ib.blue, 8'd0};
        endcase
        n = nab[k*AVG_W +: AVG_W];
        d = (p >= n) ? p - n : n - p;
        sq[k] <= d * d;
      end
    end
  end

  pffv_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sum_comb),
    .root     (root)
  );

  // Side band that travels alongside the root stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        sv[k] <= 1'b0;
      end
      vf <= 1'b0;
    end else if (adv) begin
      sv[0] <= vc;
      for (int k = 1; k < NS; k++) begin
        sv[k] <= sv[k-1];
      end
      vf <= sv[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      si[0]   <= ic;
      sna[0]  <= nac;
      sspr[0] <= sprc;
      for (int k = 1; k < NS; k++) begin
        si[k]   <= si[k-1];
        sna[k]  <= sna[k-1];
        sspr[k] <= sspr[k-1];
      end
    end
  end

  // Spread average update.
  assign target = (si[NS-1].cls == CLS_FLAME) ? root : FLOOR_TARGET;
  assign sp_sum = SP_W'(sspr[NS-1]) * SP_W'(ws_inv) + SP_W'(target) * SP_W'(ws);

  always_ff @(posedge clk) begin
    if (adv) begin
      itf  <= si[NS-1];
      naf  <= sna[NS-1];
      snew <= sp_sum[8 +: SPR_W];
    end
  end

  // Result register.
  assign scored = itf.cls == CLS_FLAME || itf.cls == CLS_PLAIN;
  assign dyn    = scored && (snew >= cfg.spread_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.dynamic_flag  <= dyn;
      out_ch.overlay_write <= dyn && cfg.overlay_enable;
      out_ch.overlay_blue  <= (dyn && cfg.overlay_enable) ? OVL_BLUE : '0;
      out_ch.overlay_green <= (dyn && cfg.overlay_enable) ? itf.green : '0;
      out_ch.overlay_red   <= (dyn && cfg.overlay_enable) ? itf.red : '0;
    end
  end

endmodule

@@ hw/rtl/pixel_flame_flicker_validator_core.sv @@
// An accepted pixel goes through the queue, then memory read, 2 math stages,
// 17 square-root stages, spread update and the result register.
// Throughput: one pixel per cycle while out_ch.ready keeps the pipeline moving; a pixel waits
// in the queue while an earlier pixel with the same index is in the 21-stage back pipeline.
// Reset clears control state and loads register defaults; the state memories are not
// cleared, and the first frame after reset loads them.
module pixel_flame_flicker_validator_core import pffv_pkg::*; #(
  parameter int NUM_PIXELS = 524288
) (
  input  logic        clk,
  input  logic        rst,
  pffv_in_if.sink     in_ch,
  pffv_out_if.source  out_ch,
  pffv_cfg_if.sink    cfg_ch
);

  cfg_t  cfg;
  logic  queue_full;
  logic  push_valid;
  item_t push_item;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_weight     <= 9'd64;
      cfg.spread_weight    <= 9'd192;
      cfg.spread_threshold <= 17'd3072;
      cfg.overlay_enable   <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.addr))
        REG_COLOR_WEIGHT:     cfg.color_weight     <= cfg_ch.data[WT_W-1:0];
        REG_SPREAD_WEIGHT:    cfg.spread_weight    <= cfg_ch.data[WT_W-1:0];
        REG_SPREAD_THRESHOLD: cfg.spread_threshold <= cfg_ch.data[THR_W-1:0];
        REG_OVERLAY_ENABLE:   cfg.overlay_enable   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  pffv_front #(.NUM_PIXELS(NUM_PIXELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  pffv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  pffv_back #(.NUM_PIXELS(NUM_PIXELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

@@ sim/pixel_flame_flicker_validator_core_tb.sv @@
// Self-checking testbench for the pixel flame flicker validator core.
module pixel_flame_flicker_validator_core_tb;
  import pffv_pkg::*;

  localparam int NPIX       = 524288;
  localparam int DRAIN_WAIT = 40;
  localparam int STALL_MAX  = 5000;

  typedef struct packed {
    logic            dynamic_flag;
    logic            overlay_write;
    logic [CH_W-1:0] overlay_blue;
    logic [CH_W-1:0] overlay_green;
    logic [CH_W-1:0] overlay_red;
  } flicker_result_t;

  logic clk;
  logic rst;

  pffv_in_if  in_ch ();
  pffv_out_if out_ch ();
  pffv_cfg_if cfg_ch ();

  pixel_flame_flicker_validator_core #(.NUM_PIXELS(NPIX)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: per-pixel averages and the register copies.
  logic [AVG_W-1:0]  color_avg [int][3];
  logic [SPR_W-1:0]  spread_avg [int];
  bit                frame_primed;
  logic [WT_W-1:0]   color_wt;
  logic [WT_W-1:0]   spread_wt;
  logic [THR_W-1:0]  spread_thr;
  logic              overlay_on;

  flicker_result_t   pending_results [$];
  int                primed_pixels [$];
  int                mismatches;
  int                results_seen;
  int                pixels_sent;
  int                flagged_seen;
  int                stall_cycles;
  int                src_idle;
  int                sink_idle;
  int                hold_cycles;
  bit                hold_req;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SPR_W-1:0] floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 17; i >= 0; i--) begin
      t = r | (longint'(1) << i);
      if (t * t <= v) r = t;
    end
    return r[SPR_W-1:0];
  endfunction

  function automatic int unsigned eff_weight(logic [WT_W-1:0] w);
    return (w > ONE_FIX) ? 256 : int'(w);
  endfunction

  // Computes the expected result for one pixel and updates the per-pixel state.
  function automatic flicker_result_t predict_flicker(int idx, logic [7:0] b, logic [7:0] g,
                                                      logic [7:0] r, bit flame, bit last);
    flicker_result_t  res;
    logic [7:0]       pix [3];
    longint unsigned  sum;
    longint unsigned  s;
    int unsigned      wc;
    int unsigned      ws;
    int unsigned      p;
    int unsigned      na;
    int unsigned      d;
    logic [SPR_W-1:0] target;
    res = '0;
    pix[0] = b;
    pix[1] = g;
    pix[2] = r;
    if (!frame_primed) begin
      for (int k = 0; k < 3; k++) color_avg[idx][k] = {pix[k], 8'h00};
      spread_avg[idx] = '0;
      if (last) frame_primed = 1'b1;
      return res;
    end
    wc = eff_weight(color_wt);
    ws = eff_weight(spread_wt);
    target = FLOOR_TARGET;
    if (flame) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        p = int'(pix[k]) << 8;
        na = (int'(color_avg[idx][k]) * (256 - wc) + p * wc) >> 8;
        color_avg[idx][k] = na[AVG_W-1:0];
        d = (p >= na) ? p - na : na - p;
        sum += longint'(d) * longint'(d);
      end
      target = floor_root(sum);
    end
    s = (longint'(spread_avg[idx]) * (256 - ws) + longint'(target) * ws) >> 8;
    spread_avg[idx] = s[SPR_W-1:0];
    res.dynamic_flag = (spread_avg[idx] >= spread_thr);
    if (res.dynamic_flag && overlay_on) begin
      res.overlay_write = 1'b1;
      res.overlay_blue  = OVL_BLUE;
      res.overlay_green = g;
      res.overlay_red   = r;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Sends one pixel, with a random gap before it, and records its expected result.
  task automatic send_pixel(int idx, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                            bit flame, bit last);
    if ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_index <= idx[IDX_W-1:0];
    in_ch.blue        <= b;
    in_ch.green       <= g;
    in_ch.red         <= r;
    in_ch.flame_color <= flame;
    in_ch.frame_end   <= last;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_flicker(idx, b, g, r, flame, last));
    pixels_sent++;
    @(negedge clk);
  endtask

  // Writes one register; valid drops before the next write.
  task automatic write_reg(cfg_reg_t which, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= which;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (which)
      REG_COLOR_WEIGHT:     color_wt = value[WT_W-1:0];
      REG_SPREAD_WEIGHT:    spread_wt = value[WT_W-1:0];
      REG_SPREAD_THRESHOLD: spread_thr = value[THR_W-1:0];
      REG_OVERLAY_ENABLE:   overlay_on = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every expected result is back and the pipeline has emptied.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic int pick_pixel();
    return primed_pixels[$urandom_range(primed_pixels.size() - 1)];
  endfunction

  // The first frame loads the state at a set of fixed and random indices.
  task automatic test_priming();
    int idx;
    primed_pixels = '{0, NPIX - 1, 'h2AAAA, 'h55555, 1, 2, 3};
    for (int i = 0; i < 20; i++) primed_pixels.push_back(int'($urandom_range(NPIX - 1)));
    send_pixel(0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
    send_pixel(NPIX - 1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    foreach (primed_pixels[i]) begin
      idx = primed_pixels[i];
      if (i > 1)
        send_pixel(idx, 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom_range(1)), 1'b0);
    end
    // A frame end closes the priming frame; later frame ends change nothing.
    send_pixel(1, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
  endtask

  // Extreme distances, the weight clamp and both threshold extremes.
  task automatic test_directed();
    wait_idle();
    write_reg(REG_COLOR_WEIGHT, 0);
    write_reg(REG_SPREAD_WEIGHT, 256);
    write_reg(REG_SPREAD_THRESHOLD, 0);
    write_reg(REG_OVERLAY_ENABLE, 1);
    send_pixel(0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_pixel(NPIX - 1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
    send_pixel(1, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0);
    send_pixel(0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_COLOR_WEIGHT, 511);
    write_reg(REG_SPREAD_WEIGHT, 300);
    write_reg(REG_SPREAD_THRESHOLD, 131071);
    send_pixel(2, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0);
    send_pixel(2, 8'h55, 8'hAA, 8'h55, 1'b1, 1'b0);
    send_pixel(3, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_COLOR_WEIGHT, 256);
    write_reg(REG_SPREAD_WEIGHT, 0);
    write_reg(REG_SPREAD_THRESHOLD, 2560);
    write_reg(REG_OVERLAY_ENABLE, 0);
    send_pixel(3, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0);
    send_pixel(NPIX - 1, 8'h01, 8'h80, 8'h7F, 1'b0, 1'b1);
  endtask

  // Random pixels under a series of random register settings.
  task automatic test_random(int segments, int per_segment, bit with_hold);
    for (int s = 0; s < segments; s++) begin
      wait_idle();
      write_reg(REG_COLOR_WEIGHT, $urandom_range(2) == 0 ? 256 : $urandom_range(511));
      write_reg(REG_SPREAD_WEIGHT, $urandom_range(2) == 0 ? 256 : $urandom_range(511));
      write_reg(REG_SPREAD_THRESHOLD, $urandom_range(4) == 0 ? $urandom_range(131071)
                                                             : $urandom_range(6000));
      write_reg(REG_OVERLAY_ENABLE, $urandom_range(1));
      if (with_hold && s == 0) hold_req = 1'b1;
      for (int i = 0; i < per_segment; i++)
        send_pixel(pick_pixel(), 8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(3) != 0, 1'($urandom_range(1)));
    end
  endtask

  // Result receiver: random ready with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cycles = 300;
      hold_req = 1'b0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    flicker_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("MISMATCH unexpected result transaction at %0t", $time);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.dynamic_flag) flagged_seen++;
        if (out_ch.dynamic_flag !== want.dynamic_flag)
          report_mismatch("dynamic_flag", out_ch.dynamic_flag, want.dynamic_flag);
        if (out_ch.overlay_write !== want.overlay_write)
          report_mismatch("overlay_write", out_ch.overlay_write, want.overlay_write);
        if (out_ch.overlay_blue !== want.overlay_blue)
          report_mismatch("overlay_blue", out_ch.overlay_blue, want.overlay_blue);
        if (out_ch.overlay_green !== want.overlay_green)
          report_mismatch("overlay_green", out_ch.overlay_green, want.overlay_green);
        if (out_ch.overlay_red !== want.overlay_red)
          report_mismatch("overlay_red", out_ch.overlay_red, want.overlay_red);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else if (!rst) begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.pixel_index = '0;
    in_ch.blue = '0;
    in_ch.green = '0;
    in_ch.red = '0;
    in_ch.flame_color = 1'b0;
    in_ch.frame_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_COLOR_WEIGHT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    frame_primed = 1'b0;
    color_wt = 9'd64;
    spread_wt = 9'd192;
    spread_thr = 17'd3072;
    overlay_on = 1'b0;
    mismatches = 0;
    results_seen = 0;
    pixels_sent = 0;
    flagged_seen = 0;
    stall_cycles = 0;
    hold_cycles = 0;
    hold_req = 1'b0;
    src_idle = 30;
    sink_idle = 78;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_priming();
    test_directed();
    test_random(4, 95, 1'b1);
    src_idle = 78;
    sink_idle = 30;
    test_random(4, 95, 1'b0);
    src_idle = 0;
    sink_idle = 0;
    test_random(4, 95, 1'b1);
    wait_idle();

    $display("tb: %0d pixels sent, %0d results checked, %0d with the dynamic flag set.",
             pixels_sent, results_seen, flagged_seen);
    $display("tb: covered priming, weight clamping, threshold extremes, overlay and stalls.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
